/* hw/rtl/tsb_pkg.sv */
package tsb_pkg;

	localparam int MAX_WIDTH_D = 128;
	localparam int MAX_HEIGHT_D = 128;
	localparam int COORD_FRAC_BITS_D = 16;
	localparam int WEIGHT_BITS_D = 8;

	localparam logic [2:0] AM_NONE = 3'd0;
	localparam logic [2:0] AM_CLAMP = 3'd1;
	localparam logic [2:0] AM_MIRROR = 3'd2;
	localparam logic [2:0] AM_MIRROR_ONCE = 3'd3;
	localparam logic [2:0] AM_WRAP = 3'd4;

	localparam logic [1:0] FM_POINT = 2'd0;
	localparam logic [1:0] FM_BILINEAR = 2'd1;
	localparam logic [1:0] FM_TRILINEAR = 2'd2;
	localparam logic [1:0] FM_BAD = 2'd3;

	localparam logic [1:0] CFG_WIDTH = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_ADDR_MODE = 2'd2;
	localparam logic [1:0] CFG_FILTER_MODE = 2'd3;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	typedef struct packed {
		logic        action;
		logic [6:0]  texel_x;
		logic [6:0]  texel_y;
		logic [31:0] texel_value;
		logic signed [31:0] coord_u;
		logic signed [31:0] coord_v;
	} req_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} rsp_t;

	typedef struct packed {
		logic [2:0] index;
		logic [7:0] data;
	} cfg_t;

endpackage

/* hw/rtl/tsb_ram.sv */
module tsb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hw/rtl/tsb_addr.sv */
module tsb_addr #(
	parameter int FB = 16
) (
	input  logic [2:0]         mode,
	input  logic signed [31:0] c,
	output logic signed [33:0] a
);

	localparam logic signed [33:0] ONE = 34'sd1 <<< FB;
	localparam logic signed [33:0] TWO = 34'sd2 <<< FB;

	logic signed [33:0] cx, cc, ab, t;

	always_comb begin
		cx = 34'(c);
		cc = cx;
		if (mode == tsb_pkg::AM_MIRROR_ONCE) begin
			if (cx < -ONE) cc = -ONE;
			else if (cx > TWO) cc = TWO;
		end
		ab = cc[33] ? -cc : cc;
		t = 34'(ab[FB:0]);
		case (mode)
			tsb_pkg::AM_CLAMP: a = cx < 0 ? '0 : (cx > ONE ? ONE : cx);
			tsb_pkg::AM_MIRROR, tsb_pkg::AM_MIRROR_ONCE: a = t > ONE ? TWO - t : t;
			tsb_pkg::AM_WRAP: a = 34'(cx[FB-1:0]);
			default: a = cx;
		endcase
	end

endmodule

/* hw/rtl/texture_sampler_bilinear.sv */
// channel | dir | signals
// req     | in  | req_valid, req_ready, req (action, texel, coords)
// rsp     | out | rsp_valid, rsp_ready, rsp (red, green, blue, alpha)
// cfg     | in  | cfg_valid, cfg_ready, cfg (index, data)
// one request per cycle unless stalled; a sample passes the s1, s2, s3 and output registers
// the texel store is four banks split by x and y parity, one read each per cycle unless stalled
// a write is one store update and yields no response
// the pipeline advances only when the output register is free or being taken
// reset clears configuration and valid flags; store contents are undefined
module texture_sampler_bilinear #(
	parameter int MAX_WIDTH = tsb_pkg::MAX_WIDTH_D,
	parameter int MAX_HEIGHT = tsb_pkg::MAX_HEIGHT_D,
	parameter int COORD_FRAC_BITS = tsb_pkg::COORD_FRAC_BITS_D,
	parameter int WEIGHT_BITS = tsb_pkg::WEIGHT_BITS_D
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  tsb_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output tsb_pkg::rsp_t  rsp,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  tsb_pkg::cfg_t  cfg
);

	localparam int FB = COORD_FRAC_BITS;
	localparam int WB = WEIGHT_BITS;
	localparam int BD = (MAX_WIDTH / 2 + 1) * (MAX_HEIGHT / 2 + 1);
	localparam int BA = $clog2(BD);
	localparam int BW = MAX_WIDTH / 2 + 1;
	localparam int DS = FB - WB;

	logic [7:0] width_q, height_q;
	logic [2:0] amode_q;
	logic [1:0] fmode_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= '0; height_q <= '0; amode_q <= '0; fmode_q <= '0;
		end else if (cfg_valid) begin
			case (cfg.index)
				3'(tsb_pkg::CFG_WIDTH): width_q <= cfg.data;
				3'(tsb_pkg::CFG_HEIGHT): height_q <= cfg.data;
				3'(tsb_pkg::CFG_ADDR_MODE): amode_q <= cfg.data[2:0];
				3'(tsb_pkg::CFG_FILTER_MODE): fmode_q <= cfg.data[1:0];
				default: ;
			endcase
		end
	end

	logic adv;
	logic v_s1, v_s2, v_s3;
	assign adv = !rsp_valid || rsp_ready;
	assign req_ready = adv;
	logic acc;
	assign acc = req_valid && req_ready;

	// stage 0: addressing and size clamp
	logic [12:0] wsat, hsat, wm, hm;
	logic signed [33:0] ua, va;
	always_comb begin
		wsat = (13'(width_q) > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : 13'(width_q);
		hsat = (13'(height_q) > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : 13'(height_q);
		wm = wsat - 13'd1;
		hm = hsat - 13'd1;
	end
	tsb_addr #(.FB(FB)) u_au (.mode(amode_q), .c(req.coord_u), .a(ua));
	tsb_addr #(.FB(FB)) u_av (.mode(amode_q), .c(req.coord_v), .a(va));

	logic black_s1, pt_s1;
	logic signed [33:0] u_s1, v_s1c;
	logic [12:0] wm_s1, hm_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= acc && req.action == tsb_pkg::ACT_SAMPLE;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			black_s1 <= wsat == 0 || hsat == 0 || fmode_q == tsb_pkg::FM_BAD;
			pt_s1 <= fmode_q == tsb_pkg::FM_POINT;
			u_s1 <= ua; v_s1c <= va; wm_s1 <= wm; hm_s1 <= hm;
		end
	end

	// stage 1: scale by size minus one, clamp, split into index and weight; point mode rounds
	logic signed [47:0] xs_m, ys_m;
	logic [FB+12:0] xs, ys;
	logic [12:0] x0, y0, x1, y1, px, py;
	logic [FB-1:0] fx, fy;
	logic [WB:0] wx, wy;
	logic [FB+12:0] xr, yr;
	always_comb begin
		xs_m = 48'(u_s1) * $signed({35'd0, wm_s1});
		ys_m = 48'(v_s1c) * $signed({35'd0, hm_s1});
		if (xs_m < 0) xs = '0;
		else if (xs_m > 48'({wm_s1, FB'(0)})) xs = {wm_s1, FB'(0)};
		else xs = xs_m[FB+12:0];
		if (ys_m < 0) ys = '0;
		else if (ys_m > 48'({hm_s1, FB'(0)})) ys = {hm_s1, FB'(0)};
		else ys = ys_m[FB+12:0];
		xr = xs + (FB+13)'(1 << (FB - 1));
		yr = ys + (FB+13)'(1 << (FB - 1));
		px = xr[FB+12:FB] > wm_s1 ? wm_s1 : xr[FB+12:FB];
		py = yr[FB+12:FB] > hm_s1 ? hm_s1 : yr[FB+12:FB];
		x0 = xs[FB+12:FB];
		y0 = ys[FB+12:FB];
		fx = xs[FB-1:0];
		fy = ys[FB-1:0];
		x1 = x0 + 13'd1 > wm_s1 ? wm_s1 : x0 + 13'd1;
		y1 = y0 + 13'd1 > hm_s1 ? hm_s1 : y0 + 13'd1;
		if (DS > 0) begin
			wx = (WB+1)'(({1'b0, fx} + (FB+1)'(1 << (DS > 0 ? DS - 1 : 0))) >> DS);
			wy = (WB+1)'(({1'b0, fy} + (FB+1)'(1 << (DS > 0 ? DS - 1 : 0))) >> DS);
		end else begin
			wx = (WB+1)'({1'b0, fx} << (DS > 0 ? 0 : -DS));
			wy = (WB+1)'({1'b0, fy} << (DS > 0 ? 0 : -DS));
		end
		if (pt_s1) begin
			x0 = px; x1 = px; y0 = py; y1 = py; wx = '0; wy = '0;
		end
	end

	// bank b = {y parity, x parity}; x0/x1 and y0/y1 cover both parities unless clamped to one index
	logic [BA-1:0] ra [4];
	logic [3:0] we;
	logic [BA-1:0] wa;
	logic [31:0] rd [4];
	logic [12:0] xe, xo, ye, yo;
	always_comb begin
		xe = x0[0] ? x1 : x0;
		xo = x0[0] ? x0 : x1;
		ye = y0[0] ? y1 : y0;
		yo = y0[0] ? y0 : y1;
		ra[0] = BA'(32'(ye >> 1) * BW + 32'(xe >> 1));
		ra[1] = BA'(32'(ye >> 1) * BW + 32'(xo >> 1));
		ra[2] = BA'(32'(yo >> 1) * BW + 32'(xe >> 1));
		ra[3] = BA'(32'(yo >> 1) * BW + 32'(xo >> 1));
		wa = BA'(32'(req.texel_y >> 1) * BW + 32'(req.texel_x >> 1));
		for (int b = 0; b < 4; b++) begin
			we[b] = acc && req.action == tsb_pkg::ACT_WRITE
				&& 32'(req.texel_x) < MAX_WIDTH && 32'(req.texel_y) < MAX_HEIGHT
				&& req.texel_x[0] == b[0] && req.texel_y[0] == b[1];
		end
	end

	// read data holds while the pipeline stalls
	logic rd_en;
	assign rd_en = adv;

	for (genvar b = 0; b < 4; b++) begin : g_bank
		tsb_ram #(.WIDTH(32), .DEPTH(BD)) u_ram (
			.clk(clk), .we(we[b]), .waddr(wa), .wdata(req.texel_value),
			.re(rd_en), .raddr(ra[b]), .rdata(rd[b])
		);
	end

	logic black_s2, x0o_s2, y0o_s2, xeq_s2, yeq_s2;
	logic [WB:0] wx_s2, wy_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			black_s2 <= black_s1; x0o_s2 <= x0[0]; y0o_s2 <= y0[0];
			xeq_s2 <= x0 == x1; yeq_s2 <= y0 == y1;
			wx_s2 <= wx; wy_s2 <= wy;
		end
	end

	// stage 2: horizontal blend
	logic [31:0] t00, t10, t01, t11;
	logic [WB+8:0] top [4], bot [4];
	always_comb begin
		t00 = rd[{y0o_s2, x0o_s2}];
		t10 = xeq_s2 ? t00 : rd[{y0o_s2, ~x0o_s2}];
		t01 = yeq_s2 ? t00 : rd[{~y0o_s2, x0o_s2}];
		t11 = xeq_s2 ? t01 : (yeq_s2 ? t10 : rd[{~y0o_s2, ~x0o_s2}]);
		for (int c = 0; c < 4; c++) begin
			top[c] = (WB+9)'(t00[8*c +: 8]) * ((WB+9)'(1 << WB) - (WB+9)'(wx_s2))
				+ (WB+9)'(t10[8*c +: 8]) * (WB+9)'(wx_s2);
			bot[c] = (WB+9)'(t01[8*c +: 8]) * ((WB+9)'(1 << WB) - (WB+9)'(wx_s2))
				+ (WB+9)'(t11[8*c +: 8]) * (WB+9)'(wx_s2);
		end
	end

	logic black_s3;
	logic [WB:0] wy_s3;
	logic [WB+8:0] top_s3 [4], bot_s3 [4];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			black_s3 <= black_s2; wy_s3 <= wy_s2; top_s3 <= top; bot_s3 <= bot;
		end
	end

	// stage 3: vertical blend and round, or opaque black for a zero size or bad filter mode
	logic [2*WB+9:0] sum [4];
	logic [31:0] pix;
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			sum[c] = (2*WB+10)'(top_s3[c]) * ((2*WB+10)'(1 << WB) - (2*WB+10)'(wy_s3))
				+ (2*WB+10)'(bot_s3[c]) * (2*WB+10)'(wy_s3)
				+ (2*WB+10)'(1 << (2*WB - 1));
			sum[c] = sum[c] >> (2*WB);
			pix[8*c +: 8] = sum[c] > 255 ? 8'hff : sum[c][7:0];
		end
		if (black_s3) pix = 32'h0000_00ff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rsp_valid <= 1'b0;
		else if (adv) rsp_valid <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (adv) rsp <= pix;
	end

endmodule
